// ----- hdl/fcpl_pkg.sv -----
// ----------------------------------------------------------------------------
// fcpl_pkg
// Shared types, constants and helper functions of the phase-current front end.
// ----------------------------------------------------------------------------
package fcpl_pkg;

  localparam int ADC_BITS          = 12;
  localparam int ANGLE_BITS        = 16;
  localparam int FILTER_EXTRA_BITS = 8;
  localparam int GAIN_BITS         = 20;
  localparam int COEFF_BITS        = 16;
  localparam int CUR_BITS          = 16;
  localparam int STATE_BITS        = CUR_BITS + FILTER_EXTRA_BITS;
  localparam int ACC_BITS          = 48;
  localparam int MUL_A_BITS        = 25;
  localparam int MUL_B_BITS        = 21;
  localparam int CORDIC_ITERS      = 16;
  localparam int CORDIC_IDX_BITS   = 4;
  localparam int TRIG_BITS         = 20;
  localparam int ANGLE_ACC_BITS    = 34;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 20;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ADC_OFFSET   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CURRENT_GAIN = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FILTER_COEFF = 2'd2;

  localparam logic [ADC_BITS-1:0]   OFFSET_RESET = 12'd2048;
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET   = 20'd267533;
  localparam logic [COEFF_BITS-1:0] COEFF_RESET  = 16'd13107;

  localparam logic signed [MUL_B_BITS-1:0] INV_SQRT3 = 21'sd37837;
  localparam logic signed [TRIG_BITS-1:0]  CORDIC_START = 20'sd39797;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IA,
    ST_IB,
    ST_HOLD_IB,
    ST_BETA,
    ST_WAIT,
    ST_D1,
    ST_D2,
    ST_Q1,
    ST_Q2,
    ST_FD,
    ST_FQ,
    ST_FQ2,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic en;
    logic load;
    logic sub;
  } mac_ctrl_t;

  function automatic logic signed [ANGLE_ACC_BITS-1:0] atan_step(
    input logic [CORDIC_IDX_BITS-1:0] i
  );
    logic signed [ANGLE_ACC_BITS-1:0] r;
    case (i)
      4'd0:    r = 34'sd536870912;
      4'd1:    r = 34'sd316933406;
      4'd2:    r = 34'sd167458907;
      4'd3:    r = 34'sd85004756;
      4'd4:    r = 34'sd42667331;
      4'd5:    r = 34'sd21354465;
      4'd6:    r = 34'sd10679838;
      4'd7:    r = 34'sd5340245;
      4'd8:    r = 34'sd2670163;
      4'd9:    r = 34'sd1335087;
      4'd10:   r = 34'sd667544;
      4'd11:   r = 34'sd333772;
      4'd12:   r = 34'sd166886;
      4'd13:   r = 34'sd83443;
      4'd14:   r = 34'sd41722;
      default: r = 34'sd20861;
    endcase
    return r;
  endfunction

  function automatic logic signed [ACC_BITS-1:0] round16(
    input logic signed [ACC_BITS-1:0] v
  );
    logic signed [ACC_BITS-1:0] t;
    t = v + 48'sd32768;
    return t >>> 16;
  endfunction

  function automatic logic signed [CUR_BITS-1:0] sat16(
    input logic signed [ACC_BITS-1:0] v
  );
    logic signed [CUR_BITS-1:0] r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[CUR_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [ACC_BITS-1:0] v
  );
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    logic signed [STATE_BITS-1:0] r;
    hi = (48'sd1 <<< (STATE_BITS - 1)) - 48'sd1;
    lo = -hi - 48'sd1;
    if (v > hi) begin
      r = hi[STATE_BITS-1:0];
    end else if (v < lo) begin
      r = lo[STATE_BITS-1:0];
    end else begin
      r = v[STATE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/fcpl_mac.sv -----
// ----------------------------------------------------------------------------
// fcpl_mac
// Shared signed multiply-accumulate unit used for every product of the block.
// ----------------------------------------------------------------------------
module fcpl_mac (
  input  logic                                 clk,
  input  fcpl_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [fcpl_pkg::MUL_A_BITS-1:0] a,
  input  logic signed [fcpl_pkg::MUL_B_BITS-1:0] b,
  output logic signed [fcpl_pkg::ACC_BITS-1:0]   acc
);
  import fcpl_pkg::*;

  logic signed [MUL_A_BITS+MUL_B_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]              prod_ext;
  logic signed [ACC_BITS-1:0]              base;

  assign prod     = a * b;
  assign prod_ext = ACC_BITS'(prod);
  assign base     = ctrl.load ? '0 : acc;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= ctrl.sub ? base - prod_ext : base + prod_ext;
    end
  end

endmodule

// ----- hdl/fcpl_cordic.sv -----
// ----------------------------------------------------------------------------
// fcpl_cordic
// Iterative rotation-mode CORDIC giving cosine and sine of the angle in Q16.
// ----------------------------------------------------------------------------
module fcpl_cordic (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [fcpl_pkg::ANGLE_BITS-1:0]       angle,
  output logic                                  done,
  output logic signed [fcpl_pkg::TRIG_BITS-1:0] cos_val,
  output logic signed [fcpl_pkg::TRIG_BITS-1:0] sin_val
);
  import fcpl_pkg::*;

  logic signed [TRIG_BITS-1:0]      x;
  logic signed [TRIG_BITS-1:0]      y;
  logic signed [ANGLE_ACC_BITS-1:0] z;
  logic [CORDIC_IDX_BITS-1:0]       iter;
  logic                             busy;
  logic                             flip;
  logic signed [ANGLE_ACC_BITS-1:0] z0;
  logic signed [ANGLE_ACC_BITS-1:0] quarter;
  logic signed [TRIG_BITS-1:0]      xs;
  logic signed [TRIG_BITS-1:0]      ys;
  logic signed [ANGLE_ACC_BITS-1:0] step;

  assign quarter = ANGLE_ACC_BITS'(64'sd1073741824);
  assign z0 = ANGLE_ACC_BITS'($signed({angle, {(32 - ANGLE_BITS){1'b0}}}));
  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign step = atan_step(iter);
  assign cos_val = flip ? -x : x;
  assign sin_val = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      iter <= '0;
    end else if (busy) begin
      iter <= iter + 1'b1;
      if (iter == CORDIC_IDX_BITS'(CORDIC_ITERS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_START;
      y <= '0;
      if (z0 > quarter) begin
        z    <= z0 - (quarter <<< 1);
        flip <= 1'b1;
      end else if (z0 < -quarter) begin
        z    <= z0 + (quarter <<< 1);
        flip <= 1'b1;
      end else begin
        z    <= z0;
        flip <= 1'b0;
      end
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - step;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + step;
      end
    end
  end

endmodule

// ----- hdl/foc_current_clarke_park_lpf_core.sv -----
// ----------------------------------------------------------------------------
// foc_current_clarke_park_lpf_core
// The 16-step CORDIC sets the pace from input word to result word, and the
// shared multiply-accumulate unit then runs the Park and filter products one
// per cycle. One word is in work at a time: the next input word is taken only
// after the result word has been loaded into the output register.
// Synchronous reset restores the register defaults and clears both filter states.
// ----------------------------------------------------------------------------
module foc_current_clarke_park_lpf_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // adc_a [11:0], adc_b [23:12], elec_angle [39:24]
  input  logic [39:0]                         s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // phase_a_current [15:0], phase_b_current [31:16], d_current [47:32],
  // q_current [63:48]
  output logic [63:0]                         m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fcpl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fcpl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import fcpl_pkg::*;

  seq_state_t state, state_next;
  mac_ctrl_t  mac_ctrl;
  logic signed [MUL_A_BITS-1:0] mac_a;
  logic signed [MUL_B_BITS-1:0] mac_b;
  logic signed [ACC_BITS-1:0]   acc;
  logic signed [ACC_BITS-1:0]   acc_rnd;

  logic [ADC_BITS-1:0]   adc_offset;
  logic [GAIN_BITS-1:0]  current_gain;
  logic [COEFF_BITS-1:0] filter_coeff;

  logic [ADC_BITS-1:0]          adc_a;
  logic [ADC_BITS-1:0]          adc_b;
  logic signed [CUR_BITS-1:0]   ia;
  logic signed [CUR_BITS-1:0]   ib;
  logic signed [18:0]           beta;
  logic signed [CUR_BITS-1:0]   d_val;
  logic signed [CUR_BITS-1:0]   q_val;
  logic signed [STATE_BITS-1:0] d_state;
  logic signed [STATE_BITS-1:0] q_state;

  logic                         accept;
  logic                         cordic_done;
  logic signed [TRIG_BITS-1:0]  cos_val;
  logic signed [TRIG_BITS-1:0]  sin_val;

  logic signed [ADC_BITS:0]      ra;
  logic signed [ADC_BITS:0]      rb;
  logic signed [17:0]            clarke_sum;
  logic signed [MUL_A_BITS-1:0]  d_diff;
  logic signed [MUL_A_BITS-1:0]  q_diff;
  logic signed [ACC_BITS-1:0]    d_out_rnd;
  logic signed [ACC_BITS-1:0]    q_out_rnd;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign acc_rnd   = round16(acc);

  assign ra = $signed({1'b0, adc_a}) - $signed({1'b0, adc_offset});
  assign rb = $signed({1'b0, adc_b}) - $signed({1'b0, adc_offset});
  assign clarke_sum = 18'(ia) + (18'(ib) <<< 1);
  assign d_diff = (MUL_A_BITS'(d_val) <<< FILTER_EXTRA_BITS) - MUL_A_BITS'(d_state);
  assign q_diff = (MUL_A_BITS'(q_val) <<< FILTER_EXTRA_BITS) - MUL_A_BITS'(q_state);
  assign d_out_rnd = (ACC_BITS'(d_state) + (48'sd1 <<< (FILTER_EXTRA_BITS - 1)))
                     >>> FILTER_EXTRA_BITS;
  assign q_out_rnd = (ACC_BITS'(q_state) + (48'sd1 <<< (FILTER_EXTRA_BITS - 1)))
                     >>> FILTER_EXTRA_BITS;

  fcpl_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .angle   (s_tdata[39:24]),
    .done    (cordic_done),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  fcpl_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_offset   <= OFFSET_RESET;
      current_gain <= GAIN_RESET;
      filter_coeff <= COEFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ADC_OFFSET:   adc_offset   <= cfg_data[ADC_BITS-1:0];
        CFG_CURRENT_GAIN: current_gain <= cfg_data[GAIN_BITS-1:0];
        CFG_FILTER_COEFF: filter_coeff <= cfg_data[COEFF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mac_ctrl   = '{en: 1'b0, load: 1'b0, sub: 1'b0};
    mac_a      = '0;
    mac_b      = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_IA;
        end
      end
      ST_IA: begin
        mac_ctrl   = '{en: 1'b1, load: 1'b1, sub: 1'b0};
        mac_a      = MUL_A_BITS'(ra);
        mac_b      = $signed({1'b0, current_gain});
        state_next = ST_IB;
      end
      ST_IB: begin
        mac_ctrl   = '{en: 1'b1, load: 1'b1, sub: 1'b0};
        mac_a      = MUL_A_BITS'(rb);
        mac_b      = $signed({1'b0, current_gain});
        state_next = ST_HOLD_IB;
      end
      ST_HOLD_IB: begin
        state_next = ST_BETA;
      end
      ST_BETA: begin
        mac_ctrl   = '{en: 1'b1, load: 1'b1, sub: 1'b0};
        mac_a      = MUL_A_BITS'(clarke_sum);
        mac_b      = INV_SQRT3;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (cordic_done) begin
          state_next = ST_D1;
        end
      end
      ST_D1: begin
        mac_ctrl   = '{en: 1'b1, load: 1'b1, sub: 1'b0};
        mac_a      = MUL_A_BITS'(ia);
        mac_b      = MUL_B_BITS'(cos_val);
        state_next = ST_D2;
      end
      ST_D2: begin
        mac_ctrl   = '{en: 1'b1, load: 1'b0, sub: 1'b0};
        mac_a      = MUL_A_BITS'(beta);
        mac_b      = MUL_B_BITS'(sin_val);
        state_next = ST_Q1;
      end
      ST_Q1: begin
        mac_ctrl   = '{en: 1'b1, load: 1'b1, sub: 1'b0};
        mac_a      = MUL_A_BITS'(beta);
        mac_b      = MUL_B_BITS'(cos_val);
        state_next = ST_Q2;
      end
      ST_Q2: begin
        mac_ctrl   = '{en: 1'b1, load: 1'b0, sub: 1'b1};
        mac_a      = MUL_A_BITS'(ia);
        mac_b      = MUL_B_BITS'(sin_val);
        state_next = ST_FD;
      end
      ST_FD: begin
        mac_ctrl   = '{en: 1'b1, load: 1'b1, sub: 1'b0};
        mac_a      = d_diff;
        mac_b      = $signed({5'b0, filter_coeff});
        state_next = ST_FQ;
      end
      ST_FQ: begin
        mac_ctrl   = '{en: 1'b1, load: 1'b1, sub: 1'b0};
        mac_a      = q_diff;
        mac_b      = $signed({5'b0, filter_coeff});
        state_next = ST_FQ2;
      end
      ST_FQ2: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_state <= '0;
      q_state <= '0;
    end else begin
      case (state)
        ST_FQ:   d_state <= sat_state(ACC_BITS'(d_state) + acc_rnd);
        ST_FQ2:  q_state <= sat_state(ACC_BITS'(q_state) + acc_rnd);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      adc_a <= s_tdata[11:0];
      adc_b <= s_tdata[23:12];
    end
    case (state)
      ST_IB:      ia    <= sat16(acc_rnd);
      ST_HOLD_IB: ib    <= sat16(acc_rnd);
      ST_WAIT:    beta  <= acc_rnd[18:0];
      ST_Q1:      d_val <= sat16(acc_rnd);
      ST_FD:      q_val <= sat16(acc_rnd);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {sat16(q_out_rnd), sat16(d_out_rnd), ib, ia};
    end
  end

endmodule

// ----- test/tb_foc_current_clarke_park_lpf_core.sv -----
// ----------------------------------------------------------------------------
// tb_foc_current_clarke_park_lpf_core
// Self-checking bench for the phase-current front end. A bit-exact predictor
// of the phase currents, the Clarke and Park stages and the two low-pass
// filters feeds a scoreboard; every output word is checked against it in
// order, under random idling on both stream sides and several register sets.
// ----------------------------------------------------------------------------
module tb_foc_current_clarke_park_lpf_core;
  import fcpl_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [15:0] ia;
    logic [15:0] ib;
    logic [15:0] d;
    logic [15:0] q;
  } frame_t;

  class current_scoreboard;
    longint offset;
    longint gain;
    longint coeff;
    longint d_state;
    longint q_state;
    frame_t pending[$];
    int errors;

    function void clear();
      offset = OFFSET_RESET;
      gain = GAIN_RESET;
      coeff = COEFF_RESET;
      d_state = 0;
      q_state = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      if (idx == CFG_ADC_OFFSET) begin
        offset = val[ADC_BITS-1:0];
      end else if (idx == CFG_CURRENT_GAIN) begin
        gain = val;
      end else if (idx == CFG_FILTER_COEFF) begin
        coeff = val[COEFF_BITS-1:0];
      end
    endfunction

    function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    function longint rshift(longint v, int s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip(longint v, int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function void trig(logic [15:0] ang, output longint c, output longint s);
      longint atans[16];
      longint z, x, y, xs, ys;
      bit flip;
      atans = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861};
      z = longint'({ang, 16'd0});
      if (z >= 64'sd2147483648) z = z - 64'sd4294967296;
      flip = 0;
      x = 39797;
      y = 0;
      if (z > 64'sd1073741824) begin
        z -= 64'sd2147483648; flip = 1;
      end else if (z < -64'sd1073741824) begin
        z += 64'sd2147483648; flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        xs = fshift(x, i);
        ys = fshift(y, i);
        if (z >= 0) begin
          x -= ys; y += xs; z -= atans[i];
        end else begin
          x += ys; y -= xs; z += atans[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint smooth(ref longint st, input longint x);
      longint stp;
      stp = rshift(coeff * ((x <<< FILTER_EXTRA_BITS) - st), 16);
      st = clip(st + stp, STATE_BITS);
      return clip(rshift(st, FILTER_EXTRA_BITS), 16);
    endfunction

    function void note_input(logic [39:0] w);
      longint ia, ib, beta, c, s, d, q, fd, fq;
      frame_t f;
      ia = clip(rshift((longint'(w[11:0]) - offset) * gain, 16), 16);
      ib = clip(rshift((longint'(w[23:12]) - offset) * gain, 16), 16);
      beta = rshift((ia + 2 * ib) * 37837, 16);
      trig(w[39:24], c, s);
      d = clip(rshift(ia * c + beta * s, 16), 16);
      q = clip(rshift(beta * c - ia * s, 16), 16);
      fd = smooth(d_state, d);
      fq = smooth(q_state, q);
      f.ia = ia[15:0];
      f.ib = ib[15:0];
      f.d = fd[15:0];
      f.q = fq[15:0];
      pending.push_back(f);
    endfunction

    function void report(string what, logic [15:0] got, logic [15:0] exp);
      $display("error: %s got %0d expected %0d", what, $signed(got), $signed(exp));
      errors++;
    endfunction

    function void check_output(logic [63:0] w);
      frame_t f;
      if (pending.size() == 0) begin
        $display("error: unexpected word %h", w);
        errors++;
        return;
      end
      f = pending.pop_front();
      if (w[15:0] !== f.ia) report("phase_a_current", w[15:0], f.ia);
      if (w[31:16] !== f.ib) report("phase_b_current", w[31:16], f.ib);
      if (w[47:32] !== f.d) report("d_current", w[47:32], f.d);
      if (w[63:48] !== f.q) report("q_current", w[63:48], f.q);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  int send_idle_pct;
  int recv_idle_pct;
  longint cycles = 0;
  current_scoreboard sb;

  foc_current_clarke_park_lpf_core uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("foc_current_clarke_park_lpf_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_word(logic [11:0] a, logic [11:0] b, logic [15:0] ang);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    s_tvalid <= 1;
    s_tdata <= {ang, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input({ang, b, a});
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_words(int n);
    logic [11:0] a, b;
    for (int i = 0; i < n; i++) begin
      a = 12'($urandom);
      b = 12'($urandom);
      if ($urandom_range(3) == 0) begin
        a = 12'(2048 + $urandom_range(200) - 100);
        b = 12'(2048 + $urandom_range(200) - 100);
      end
      send_word(a, b, 16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_word(12'd0, 12'd0, 16'd0);
    send_word(12'hfff, 12'hfff, 16'hffff);
    send_word(12'd2048, 12'd2048, 16'h4000);
    send_word(12'hfff, 12'd0, 16'h8000);
    send_word(12'd0, 12'hfff, 16'hc000);
    send_word(12'd3000, 12'd1000, 16'h4001);
    send_word(12'd1000, 12'd3000, 16'hbfff);
    send_word(12'd2500, 12'd1800, 16'h7fff);
    drain();
    write_reg(CFG_CURRENT_GAIN, 20'hfffff);
    write_reg(CFG_FILTER_COEFF, 20'hffff);
    write_reg(CFG_ADC_OFFSET, 20'd0);
    send_word(12'hfff, 12'hfff, 16'h2000);
    send_word(12'd0, 12'd1, 16'he000);
    drain();
    write_reg(CFG_FILTER_COEFF, 20'd0);
    write_reg(CFG_ADC_OFFSET, 20'hfff);
    send_word(12'd0, 12'd0, 16'h1234);
    send_word(12'd5, 12'hfff, 16'h9876);
    drain();
    write_reg(CFG_ADC_OFFSET, 20'd2048);
    write_reg(CFG_CURRENT_GAIN, 20'd267533);
    write_reg(CFG_FILTER_COEFF, 20'd13107);
    write_reg(CFG_UNUSED, 20'd12345);

    send_idle_pct = 28;
    recv_idle_pct = 51;
    random_words(300);
    drain();
    write_reg(CFG_ADC_OFFSET, 20'($urandom_range(4095)));
    write_reg(CFG_CURRENT_GAIN, 20'($urandom_range(1048575)));
    write_reg(CFG_FILTER_COEFF, 20'($urandom_range(65535)));
    send_idle_pct = 51;
    recv_idle_pct = 28;
    random_words(300);
    drain();
    write_reg(CFG_ADC_OFFSET, 20'd2048);
    write_reg(CFG_CURRENT_GAIN, 20'd65536);
    write_reg(CFG_FILTER_COEFF, 20'd40000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_words(300);
    drain();

    if (sb.errors == 0) begin
      $display("foc_current_clarke_park_lpf_core: match");
    end else begin
      $display("foc_current_clarke_park_lpf_core: mismatch");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/fcpl_pkg.sv
hdl/fcpl_mac.sv
hdl/fcpl_cordic.sv
hdl/foc_current_clarke_park_lpf_core.sv
test/tb_foc_current_clarke_park_lpf_core.sv
